// ===== sv/hamming_nearest_neighbour_matcher_assert.svh =====
// Assertion macros for the Hamming nearest neighbor matcher.
`ifndef HAMMING_NEAREST_NEIGHBOUR_MATCHER_ASSERT_SVH
`define HAMMING_NEAREST_NEIGHBOUR_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during rst.
`define HNNM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hnnm assertion failed");

// Next-cycle implication, sampled on clk, held off during rst.
`define HNNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hnnm assertion failed");

`endif

// ===== sv/hnnm_pkg.sv =====
// Shared types, constants and helpers for the Hamming nearest neighbor matcher.
package hnnm_pkg;

  localparam int DESC_BITS    = 256;
  localparam int WORD_BITS    = 64;
  localparam int MAX_FEATURES = 2048;
  localparam int IDX_W        = $clog2(MAX_FEATURES);
  localparam int DIST_W       = 9;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 2;
  localparam int NUM_BYTES    = 32;

  localparam logic [DIST_W-1:0] NO_DIST       = 9'd256;
  localparam logic [CFG_W-1:0]  THRESH_RESET  = 9'd50;
  localparam logic [CFG_W-1:0]  RATIO_RESET   = 9'd192;
  localparam logic [255:0]      DESC_MASK     = {256{1'b1}} >> (256 - DESC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RATIO     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] threshold;
    logic [CFG_W-1:0] ratio;
  } hnnm_cfg_t;

  // One scored candidate on its way to the tracker
  typedef struct packed {
    logic [DIST_W-1:0] hdist;
    logic [IDX_W-1:0]  idx;
    logic              taken;
    logic              first;
    logic              last;
  } hnnm_item_t;

  // Count the set bits of one byte
  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + {3'b000, b[i]};
    end
    return cnt;
  endfunction

endpackage

// ===== sv/hnnm_dist.sv =====
// Input register, Hamming distance tree and scored-candidate register.
module hnnm_dist (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [63:0]                query_w0,
  input  logic [63:0]                query_w1,
  input  logic [63:0]                query_w2,
  input  logic [63:0]                query_w3,
  input  logic [63:0]                cand_w0,
  input  logic [63:0]                cand_w1,
  input  logic [63:0]                cand_w2,
  input  logic [63:0]                cand_w3,
  input  logic [hnnm_pkg::IDX_W-1:0] cand_index,
  input  logic                       cand_taken,
  input  logic                       first_cand,
  input  logic                       last_cand,
  output logic                       item_valid,
  input  logic                       item_ready,
  output hnnm_pkg::hnnm_item_t       item
);
  import hnnm_pkg::*;

  logic              s1_valid;
  logic [255:0]      s1_query;
  logic [255:0]      s1_cand;
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_taken;
  logic              s1_first;
  logic              s1_last;
  logic              s2_free;

  logic [255:0]      diff;
  logic [3:0]        cnt8  [NUM_BYTES];
  logic [4:0]        cnt16 [NUM_BYTES/2];
  logic [5:0]        cnt32 [NUM_BYTES/4];
  logic [6:0]        cnt64 [NUM_BYTES/8];
  logic [7:0]        cnt128[NUM_BYTES/16];
  logic [DIST_W-1:0] dist_next;

  assign s2_free  = !item_valid || item_ready;
  assign in_ready = !s1_valid || s2_free;

  // Popcount of the masked difference as a balanced adder tree
  always_comb begin
    diff = (s1_query ^ s1_cand) & DESC_MASK;
    for (int i = 0; i < NUM_BYTES; i++) begin
      cnt8[i] = pop8(diff[8*i +: 8]);
    end
    for (int i = 0; i < NUM_BYTES/2; i++) begin
      cnt16[i] = {1'b0, cnt8[2*i]} + {1'b0, cnt8[2*i+1]};
    end
    for (int i = 0; i < NUM_BYTES/4; i++) begin
      cnt32[i] = {1'b0, cnt16[2*i]} + {1'b0, cnt16[2*i+1]};
    end
    for (int i = 0; i < NUM_BYTES/8; i++) begin
      cnt64[i] = {1'b0, cnt32[2*i]} + {1'b0, cnt32[2*i+1]};
    end
    for (int i = 0; i < NUM_BYTES/16; i++) begin
      cnt128[i] = {1'b0, cnt64[2*i]} + {1'b0, cnt64[2*i+1]};
    end
    dist_next = {1'b0, cnt128[0]} + {1'b0, cnt128[1]};
  end

  // Valid bits of both stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (s2_free) begin
        item_valid <= s1_valid;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  // Capture the input beat and advance the scored candidate
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_query <= {query_w3, query_w2, query_w1, query_w0};
      s1_cand  <= {cand_w3, cand_w2, cand_w1, cand_w0};
      s1_idx   <= cand_index;
      s1_taken <= cand_taken;
      s1_first <= first_cand;
      s1_last  <= last_cand;
    end
    if (s2_free && s1_valid) begin
      item.hdist <= dist_next;
      item.idx   <= s1_idx;
      item.taken <= s1_taken;
      item.first <= s1_first;
      item.last  <= s1_last;
    end
  end

endmodule

// ===== sv/hnnm_track.sv =====
// Running best and second-best tracker with ratio test and result register.
module hnnm_track (
  input  logic                        clk,
  input  logic                        rst,
  input  hnnm_pkg::hnnm_cfg_t         cfg,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  hnnm_pkg::hnnm_item_t        item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        matched,
  output logic [hnnm_pkg::IDX_W-1:0]  match_index,
  output logic [hnnm_pkg::DIST_W-1:0] best_distance,
  output logic [hnnm_pkg::DIST_W-1:0] second_distance
);
  import hnnm_pkg::*;

  logic [DIST_W-1:0] best_dist;
  logic [DIST_W-1:0] second_dist;
  logic [IDX_W-1:0]  best_idx;
  logic              have_best;

  logic [DIST_W-1:0] best_next;
  logic [DIST_W-1:0] second_next;
  logic [IDX_W-1:0]  idx_next;
  logic              have_next;
  logic [17:0]       lhs;
  logic [17:0]       rhs;
  logic              ok;
  logic              take;
  logic              load;

  // A beat that ends a run waits only for room in the result register
  assign item_ready = !item.last || !out_valid || out_ready;
  assign take       = item_valid && item_ready;
  assign load       = take && item.last;

  // Fold the candidate into the running minima
  always_comb begin
    if (item.first) begin
      best_next   = NO_DIST;
      second_next = NO_DIST;
      idx_next    = '0;
      have_next   = 1'b0;
    end else begin
      best_next   = best_dist;
      second_next = second_dist;
      idx_next    = best_idx;
      have_next   = have_best;
    end
    if (!item.taken) begin
      if (item.hdist < best_next) begin
        second_next = best_next;
        best_next   = item.hdist;
        idx_next    = item.idx;
        have_next   = 1'b1;
      end else if (item.hdist < second_next) begin
        second_next = item.hdist;
      end
    end
    lhs = {1'b0, best_next, 8'h00};
    rhs = 18'(cfg.ratio) * 18'(second_next);
    ok  = have_next && (best_next <= cfg.threshold) && (lhs < rhs);
  end

  // Hold running state; clear it after a result
  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist   <= NO_DIST;
      second_dist <= NO_DIST;
      best_idx    <= '0;
      have_best   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        if (item.last) begin
          best_dist   <= NO_DIST;
          second_dist <= NO_DIST;
          best_idx    <= '0;
          have_best   <= 1'b0;
        end else begin
          best_dist   <= best_next;
          second_dist <= second_next;
          best_idx    <= idx_next;
          have_best   <= have_next;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      matched         <= ok;
      match_index     <= have_next ? idx_next : '0;
      best_distance   <= best_next;
      second_distance <= second_next;
    end
  end

endmodule

// ===== sv/hamming_nearest_neighbour_matcher.sv =====
// Top level: configuration registers, distance stage and minima tracker.
// A run's result passes the input register, the scored-candidate register and the result register.
// Throughput: one candidate per cycle outside the stall below; the tracker's compare loop
// on the running minima sets this figure.
// Input stalls only while a run-ending beat waits on a result that is not taken.
// Reset: synchronous, clears minima, pipeline valids and loads threshold 50, ratio 192.
`include "hamming_nearest_neighbour_matcher_assert.svh"
module hamming_nearest_neighbour_matcher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [63:0]                 query_w0,
  input  logic [63:0]                 query_w1,
  input  logic [63:0]                 query_w2,
  input  logic [63:0]                 query_w3,
  input  logic [63:0]                 cand_w0,
  input  logic [63:0]                 cand_w1,
  input  logic [63:0]                 cand_w2,
  input  logic [63:0]                 cand_w3,
  input  logic [hnnm_pkg::IDX_W-1:0]  cand_index,
  input  logic                        cand_taken,
  input  logic                        first_cand,
  input  logic                        last_cand,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        matched,
  output logic [hnnm_pkg::IDX_W-1:0]  match_index,
  output logic [hnnm_pkg::DIST_W-1:0] best_distance,
  output logic [hnnm_pkg::DIST_W-1:0] second_distance,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hnnm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hnnm_pkg::CFG_W-1:0]  cfg_data
);
  import hnnm_pkg::*;

  hnnm_cfg_t  cfg;
  hnnm_item_t item;
  logic       item_valid;
  logic       item_ready;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESH_RESET;
      cfg.ratio     <= RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold <= cfg_data;
        REG_RATIO:     cfg.ratio     <= cfg_data;
        default: ;
      endcase
    end
  end

  hnnm_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .query_w0   (query_w0),
    .query_w1   (query_w1),
    .query_w2   (query_w2),
    .query_w3   (query_w3),
    .cand_w0    (cand_w0),
    .cand_w1    (cand_w1),
    .cand_w2    (cand_w2),
    .cand_w3    (cand_w3),
    .cand_index (cand_index),
    .cand_taken (cand_taken),
    .first_cand (first_cand),
    .last_cand  (last_cand),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  hnnm_track u_track (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .matched         (matched),
    .match_index     (match_index),
    .best_distance   (best_distance),
    .second_distance (second_distance)
  );

  // Result ordering and consistency checks, and a threshold write check
  `HNNM_ASSERT_IMP(a_best_le_second, out_valid, best_distance <= second_distance)
  `HNNM_ASSERT_IMP(a_match_needs_best, out_valid && matched, best_distance != NO_DIST)
  `HNNM_ASSERT_IMP(a_empty_index_zero, out_valid && (best_distance == NO_DIST), match_index == '0)
  `HNNM_ASSERT_NEXT(a_thresh_write, cfg_valid && (cfg_index == REG_THRESHOLD), cfg.threshold == $past(cfg_data))

endmodule

// ===== tb/sv/hamming_nearest_neighbour_matcher_tb.sv =====
// Testbench for the Hamming nearest neighbor matcher: directed table, then random candidate runs.
`timescale 1ns / 1ps
module hamming_nearest_neighbour_matcher_tb;
  import hnnm_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_BEATS   = 130;
  localparam int NUM_DIRECTED  = 20;

  // Register indexes that map to nothing; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [255:0] DESC_ZERO  = {256{1'b0}};
  localparam logic [255:0] DESC_ONES  = {256{1'b1}};
  localparam logic [255:0] DESC_TOP   = {1'b1, 255'b0};
  localparam logic [255:0] DESC_LOW50 = {206'b0, {50{1'b1}}};
  localparam logic [255:0] DESC_LOW51 = {205'b0, {51{1'b1}}};
  localparam logic [255:0] PAT_A      = {4{64'hA5A5_5A5A_F00F_0FF0}};
  localparam logic [255:0] PAT_B      = {4{64'h0123_4567_89AB_CDEF}};

  typedef struct packed {
    logic              matched;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] second;
  } match_result_t;

  typedef struct packed {
    logic [255:0]     query;
    logic [255:0]     cand;
    logic [IDX_W-1:0] index;
    logic             taken;
    logic             first;
    logic             last;
    logic             typed;
    match_result_t    result;
  } cand_beat_t;

  localparam match_result_t NO_TYPED = '0;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [63:0]           query_w0, query_w1, query_w2, query_w3;
  logic [63:0]           cand_w0, cand_w1, cand_w2, cand_w3;
  logic [IDX_W-1:0]      cand_index;
  logic                  cand_taken;
  logic                  first_cand;
  logic                  last_cand;
  logic                  out_valid;
  logic                  out_ready;
  logic                  matched;
  logic [IDX_W-1:0]      match_index;
  logic [DIST_W-1:0]     best_distance;
  logic [DIST_W-1:0]     second_distance;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // Typed expectation travelling with the input beat
  logic                  beat_typed;
  match_result_t         beat_result;

  // Predictor copy of registers and running minima
  logic [CFG_W-1:0]      thr_model;
  logic [CFG_W-1:0]      ratio_model;
  logic [DIST_W-1:0]     run_best;
  logic [DIST_W-1:0]     run_second;
  logic [IDX_W-1:0]      run_idx;
  logic                  run_have;

  match_result_t         expected_matches[$];
  match_result_t         predicted;
  match_result_t         oldest;
  cand_beat_t            seen_beat;
  int unsigned           mismatch_count = 0;
  int unsigned           beats_sent = 0;
  logic                  source_calm = 1'b0;
  logic                  sink_calm = 1'b0;

  // Directed rows at threshold 50, ratio 192
  cand_beat_t directed_beats [NUM_DIRECTED] = '{
    // exact match, single candidate
    '{DESC_ZERO, DESC_ZERO, 11'd5, 1'b0, 1'b1, 1'b1, 1'b1, '{1'b1, 11'd5, 9'd0, 9'd256}},
    // distance 256 never counts
    '{DESC_ZERO, DESC_ONES, 11'd2047, 1'b0, 1'b1, 1'b1, 1'b1, '{1'b0, 11'd0, 9'd256, 9'd256}},
    // taken candidate skipped, nothing counted
    '{DESC_ONES, DESC_ONES, 11'd2047, 1'b1, 1'b1, 1'b1, 1'b1, '{1'b0, 11'd0, 9'd256, 9'd256}},
    // uncounted distance 256, then a run end without its own first mark
    '{DESC_ONES, DESC_ZERO, 11'd3, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED},
    '{DESC_ONES, DESC_ONES, 11'd2047, 1'b0, 1'b0, 1'b1, 1'b1, '{1'b1, 11'd2047, 9'd0, 9'd256}},
    // tie with the best lands in second
    '{DESC_ZERO, 256'h7, 11'd10, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED},
    '{DESC_ZERO, 256'h70, 11'd11, 1'b0, 1'b0, 1'b1, 1'b1, '{1'b0, 11'd10, 9'd3, 9'd3}},
    // run with no first mark starts from cleared state
    '{DESC_ZERO, DESC_TOP, 11'd7, 1'b0, 1'b0, 1'b1, 1'b1, '{1'b1, 11'd7, 9'd1, 9'd256}},
    // threshold edge: 50 passes, 51 fails
    '{DESC_ZERO, DESC_LOW50, 11'd100, 1'b0, 1'b1, 1'b1, 1'b1, '{1'b1, 11'd100, 9'd50, 9'd256}},
    '{DESC_ZERO, DESC_LOW51, 11'd101, 1'b0, 1'b1, 1'b1, 1'b1, '{1'b0, 11'd101, 9'd51, 9'd256}},
    // ratio edge: 3 against 4 fails, 3 against 5 passes
    '{DESC_ZERO, 256'hF, 11'd20, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED},
    '{DESC_ZERO, 256'h7 << 100, 11'd21, 1'b0, 1'b0, 1'b1, 1'b1, '{1'b0, 11'd21, 9'd3, 9'd4}},
    '{DESC_ZERO, 256'h1F, 11'd22, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED},
    '{DESC_ZERO, 256'h7 << 200, 11'd23, 1'b0, 1'b0, 1'b1, 1'b1, '{1'b1, 11'd23, 9'd3, 9'd5}},
    // closer candidate marked taken does not count
    '{DESC_ZERO, DESC_ZERO, 11'd30, 1'b1, 1'b1, 1'b0, 1'b0, NO_TYPED},
    '{DESC_ZERO, 256'hF << 60, 11'd31, 1'b0, 1'b0, 1'b1, 1'b1, '{1'b1, 11'd31, 9'd4, 9'd256}},
    // mixed patterns, query changes inside the run
    '{PAT_A, PAT_A ^ {64'hFFFF, 192'b0}, 11'd1234, 1'b0, 1'b1, 1'b0, 1'b0, NO_TYPED},
    '{PAT_A, PAT_B, 11'd0, 1'b0, 1'b0, 1'b0, 1'b0, NO_TYPED},
    '{PAT_B, PAT_A, 11'd1024, 1'b1, 1'b0, 1'b0, 1'b0, NO_TYPED},
    '{PAT_A, ~PAT_A ^ 256'h1, 11'd512, 1'b0, 1'b0, 1'b1, 1'b0, NO_TYPED}
  };

  hamming_nearest_neighbour_matcher i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .query_w0(query_w0), .query_w1(query_w1), .query_w2(query_w2), .query_w3(query_w3),
    .cand_w0(cand_w0), .cand_w1(cand_w1), .cand_w2(cand_w2), .cand_w3(cand_w3),
    .cand_index(cand_index), .cand_taken(cand_taken),
    .first_cand(first_cand), .last_cand(last_cand),
    .out_valid(out_valid), .out_ready(out_ready),
    .matched(matched), .match_index(match_index),
    .best_distance(best_distance), .second_distance(second_distance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void clear_minima();
    run_best   = NO_DIST;
    run_second = NO_DIST;
    run_idx    = '0;
    run_have   = 1'b0;
  endfunction

  // Fold one candidate into the running minima; return 1 when it closes a run
  function automatic logic track_candidate(input cand_beat_t b, output match_result_t res);
    int unsigned  hdist;
    int unsigned  lhs;
    int unsigned  rhs;
    logic [255:0] diff;
    hdist = 0;
    res   = '0;
    diff  = (b.query ^ b.cand) & DESC_MASK;
    if (b.first) begin
      clear_minima();
    end
    if (!b.taken) begin
      for (int i = 0; i < 256; i++) begin
        hdist += diff[i];
      end
      if (hdist < run_best) begin
        run_second = run_best;
        run_best   = hdist[DIST_W-1:0];
        run_idx    = b.index;
        run_have   = 1'b1;
      end else if (hdist < run_second) begin
        run_second = hdist[DIST_W-1:0];
      end
    end
    if (!b.last) begin
      return 1'b0;
    end
    lhs = run_best * 256;
    rhs = ratio_model * run_second;
    res.matched = run_have && (run_best <= thr_model) && (lhs < rhs);
    res.index   = run_have ? run_idx : '0;
    res.best    = run_best;
    res.second  = run_second;
    clear_minima();
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track register writes, predict on input beats, check result beats
  always @(posedge clk) begin
    if (rst) begin
      thr_model   = THRESH_RESET;
      ratio_model = RATIO_RESET;
      clear_minima();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: thr_model = cfg_data;
          REG_RATIO:     ratio_model = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        seen_beat.query  = {query_w3, query_w2, query_w1, query_w0};
        seen_beat.cand   = {cand_w3, cand_w2, cand_w1, cand_w0};
        seen_beat.index  = cand_index;
        seen_beat.taken  = cand_taken;
        seen_beat.first  = first_cand;
        seen_beat.last   = last_cand;
        seen_beat.typed  = beat_typed;
        seen_beat.result = beat_result;
        if (track_candidate(seen_beat, predicted)) begin
          expected_matches.insert(expected_matches.size(),
                                  beat_typed ? beat_result : predicted);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: unexpected result beat: matched %0b index %0d best %0d second %0d",
                   $time, matched, match_index, best_distance, second_distance);
          mismatch_count++;
        end else begin
          oldest = expected_matches.pop_front();
          check_field("matched", 16'(oldest.matched), 16'(matched));
          check_field("match_index", 16'(oldest.index), 16'(match_index));
          check_field("best_distance", 16'(oldest.best), 16'(best_distance));
          check_field("second_distance", 16'(oldest.second), 16'(second_distance));
        end
      end
    end
  end

  // Result side: stall a random number of cycles before each beat
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic logic [255:0] random_desc();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Present one candidate beat after a random gap and hold it until taken
  task automatic send_beat(input cand_beat_t b);
    int unsigned gap;
    gap = source_calm ? 0 : $urandom_range(7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {query_w3, query_w2, query_w1, query_w0} <= b.query;
    {cand_w3, cand_w2, cand_w1, cand_w0}     <= b.cand;
    cand_index  <= b.index;
    cand_taken  <= b.taken;
    first_cand  <= b.first;
    last_cand   <= b.last;
    beat_typed  <= b.typed;
    beat_result <= b.result;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Hold input until every expected result is out, then let the pipeline empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  initial begin
    int unsigned      run_len;
    int unsigned      kind;
    int unsigned      pick;
    int unsigned      phase_start;
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] ratio;
    logic [255:0]     run_query;
    logic [255:0]     prev_cand;
    cand_beat_t       beat;
    rst         = 1'b1;
    in_valid    = 1'b0;
    query_w0    = '0;
    query_w1    = '0;
    query_w2    = '0;
    query_w3    = '0;
    cand_w0     = '0;
    cand_w1     = '0;
    cand_w2     = '0;
    cand_w3     = '0;
    cand_index  = '0;
    cand_taken  = 1'b0;
    first_cand  = 1'b0;
    last_cand   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    beat_typed  = 1'b0;
    beat_result = '0;
    beat        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table at the reset register values
    foreach (directed_beats[r]) begin
      send_beat(directed_beats[r]);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Reprogram only while idle; spare index written last to catch aliasing
      drain_results();
      case (phase)
        0: begin thr = 9'd0;   ratio = 9'd0;   end
        1: begin thr = 9'd256; ratio = 9'd256; end
        2: begin thr = 9'd256; ratio = 9'd0;   end
        3: begin thr = 9'd0;   ratio = 9'd256; end
        4: begin thr = 9'd511; ratio = 9'd511; end
        default: begin
          thr   = 9'($urandom_range(120, 20));
          ratio = 9'($urandom_range(256, 128));
        end
      endcase
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_RATIO, ratio);
      write_reg(phase[0] ? REG_SPARE_HI : REG_SPARE_LO, 9'($urandom_range(511)));
      cfg_valid <= 1'b0;
      source_calm = (phase % 3 == 2);
      sink_calm   = source_calm;

      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if ($urandom_range(39) == 0) begin
          drain_results();
        end
        // Mostly well-formed runs; kinds 7..9 drop first marks, repeat them, or drop last
        kind    = $urandom_range(9);
        run_len = ($urandom_range(7) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
        pick    = $urandom_range(15);
        run_query = (pick == 0) ? DESC_ZERO : (pick == 1) ? DESC_ONES : random_desc();
        prev_cand = run_query;
        for (int j = 0; j < run_len; j++) begin
          beat.query = ($urandom_range(19) == 0) ? random_desc() : run_query;
          case ($urandom_range(15))
            0: beat.cand = beat.query;
            1: beat.cand = ~beat.query;
            2: beat.cand = random_desc();
            3: beat.cand = prev_cand;
            default: begin
              beat.cand = beat.query;
              repeat ($urandom_range(60)) beat.cand[8'($urandom_range(255))] ^= 1'b1;
            end
          endcase
          prev_cand = beat.cand;
          pick = $urandom_range(15);
          beat.index = (pick == 0) ? '0 : (pick == 1) ? '1 : IDX_W'($urandom_range(2047));
          beat.taken = ($urandom_range(4) == 0);
          if (kind == 7) begin
            beat.first = 1'b0;
          end else if (kind == 8) begin
            beat.first = (j == 0) || ($urandom_range(2) == 0);
          end else begin
            beat.first = (j == 0);
          end
          beat.last   = (kind != 9) && (j == run_len - 1);
          beat.typed  = 1'b0;
          beat.result = NO_TYPED;
          send_beat(beat);
        end
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
